>>> design/rwmf_pkg.sv
// ----------------------------------------------------------------------------
// rwmf_pkg
// Shared types and constants of the rgb window median filter: the input and
// output pixel structs, the window geometry and the register indexes.
// ----------------------------------------------------------------------------
package rwmf_pkg;

  localparam int MAX_RADIUS   = 2;
  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 4096;

  localparam int CHAN_W       = 8;
  localparam int PIX_W        = 3 * CHAN_W;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 13;
  localparam int CFG_W        = 13;
  localparam int RAD_W        = 2;

  localparam int WIN_SIDE     = 2 * MAX_RADIUS + 1;
  localparam int WIN_N        = WIN_SIDE * WIN_SIDE;
  localparam int CNT_W        = $clog2(WIN_N + 1);
  localparam int STORED_LINES = WIN_SIDE - 1;
  localparam int LINE_W       = STORED_LINES * PIX_W;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);

  // register indexes of the configuration port
  localparam logic [1:0] REG_RADIUS       = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;
  } pix_out_t;

endpackage

>>> design/rwmf_ram.sv
// ----------------------------------------------------------------------------
// rwmf_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data and a read enable that holds the data.
// ----------------------------------------------------------------------------
module rwmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/rwmf_rank_median.sv
// ----------------------------------------------------------------------------
// rwmf_rank_median
// Three-stage rank selector for one channel: compare matrix, rank counts,
// then pick of the masked element whose rank equals the requested index.
// ----------------------------------------------------------------------------
module rwmf_rank_median import rwmf_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         valid,
  input  logic [WIN_N-1:0][CHAN_W-1:0] values,
  input  logic [WIN_N-1:0]             mask,
  input  logic [CNT_W-1:0]             half,
  output logic [CHAN_W-1:0]            result,
  output logic                         result_valid
);

  logic                         a_valid;
  logic [WIN_N-1:0][WIN_N-1:0]  a_lt;
  logic [WIN_N-1:0][CHAN_W-1:0] a_vals;
  logic [WIN_N-1:0]             a_mask;
  logic [CNT_W-1:0]             a_half;
  logic                         b_valid;
  logic [WIN_N-1:0][CNT_W-1:0]  b_rank;
  logic [WIN_N-1:0][CHAN_W-1:0] b_vals;
  logic [WIN_N-1:0]             b_mask;
  logic [CNT_W-1:0]             b_half;

  logic [WIN_N-1:0][WIN_N-1:0]  lt_next;
  logic [WIN_N-1:0][CNT_W-1:0]  rank_next;
  logic [CHAN_W-1:0]            result_next;

  // element j ranks below element i, ties broken by position
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      for (int j = 0; j < WIN_N; j++) begin
        lt_next[i][j] = mask[j] && ((values[j] < values[i]) ||
                        ((values[j] == values[i]) && (j < i)));
      end
    end
  end

  // rank of each element among the masked ones
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      rank_next[i] = CNT_W'($countones(a_lt[i]));
    end
  end

  // exactly one masked element carries the requested rank
  always_comb begin
    result_next = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (b_mask[i] && (b_rank[i] == b_half)) begin
        result_next = result_next | b_vals[i];
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      a_valid      <= valid;
      b_valid      <= a_valid;
      result_valid <= b_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_lt   <= lt_next;
      a_vals <= values;
      a_mask <= mask;
      a_half <= half;
      b_rank <= rank_next;
      b_vals <= a_vals;
      b_mask <= a_mask;
      b_half <= a_half;
      result <= result_next;
    end
  end

endmodule

>>> design/rgb_window_median_filter_top.sv
// ----------------------------------------------------------------------------
// rgb_window_median_filter_top
// Per-channel median over a clipped square window, line buffers in one RAM.
// ----------------------------------------------------------------------------
// path: stage 1, window registers, selector compare, rank and result regs
// throughput: one pixel per cycle unless the output is held, set by the line
//   RAM read-modify-write (four stored lines per column, forwarded on reuse)
// reset: radius 1, frame 512 x 512, grid position 0, no pending results;
//   line RAM contents are not cleared
// ----------------------------------------------------------------------------
module rgb_window_median_filter_top import rwmf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  pix_in_t          pix,
  output logic             med_valid,
  input  logic             med_stall,
  output pix_out_t         med
);

  logic [RAD_W-1:0] radius;
  logic [COL_W-1:0] frame_width;
  logic [ROW_W-1:0] frame_height;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;

  logic adv;
  logic accept;

  // configuration write with clamping
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RAD_W'(1);
      frame_width  <= COL_W'(512);
      frame_height <= ROW_W'(512);
    end else if (cfg_en) begin
      case (cfg_index)
        REG_RADIUS: begin
          radius <= (cfg_data[RAD_W-1:0] > RAD_W'(MAX_RADIUS)) ?
                    RAD_W'(MAX_RADIUS) : cfg_data[RAD_W-1:0];
        end
        REG_FRAME_WIDTH: begin
          if (cfg_data[COL_W-1:0] == '0) begin
            frame_width <= COL_W'(1);
          end else if (cfg_data[COL_W-1:0] > COL_W'(MAX_WIDTH)) begin
            frame_width <= COL_W'(MAX_WIDTH);
          end else begin
            frame_width <= cfg_data[COL_W-1:0];
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_data[ROW_W-1:0] == '0) begin
            frame_height <= ROW_W'(1);
          end else if (cfg_data[ROW_W-1:0] > ROW_W'(MAX_HEIGHT)) begin
            frame_height <= ROW_W'(MAX_HEIGHT);
          end else begin
            frame_height <= cfg_data[ROW_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline advances unless the output register is held
  assign adv       = !(med_valid && med_stall);
  assign pix_stall = !adv;
  assign accept    = pix_valid && adv;

  // grid position counters
  logic col_wrap;
  logic row_wrap;

  assign col_wrap = ({1'b0, col_pos} + (COL_W+1)'(1)) >=
                    ({1'b0, frame_width} + (COL_W+1)'(radius));
  assign row_wrap = ({1'b0, row_pos} + (ROW_W+1)'(1)) >=
                    ({1'b0, frame_height} + (ROW_W+1)'(radius));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (cfg_en &&
                 (cfg_index inside {REG_RADIUS, REG_FRAME_WIDTH, REG_FRAME_HEIGHT})) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_pos <= '0;
        row_pos <= row_wrap ? '0 : row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  // stage 1 registers: transferred pixel and its position
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pix;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic              s1_emit;
  logic              s1_fe;
  logic              fwd_hit;
  logic [LINE_W-1:0] fwd_data;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [LINE_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [LINE_W-1:0] rd_data;

  assign rd_addr = col_pos[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pix;
      s1_col   <= col_pos;
      s1_row   <= row_pos;
      s1_emit  <= (col_pos >= COL_W'(radius)) && (row_pos >= ROW_W'(radius));
      s1_fe    <= (col_pos == frame_width - COL_W'(1) + COL_W'(radius)) &&
                  (row_pos == frame_height - ROW_W'(1) + ROW_W'(radius));
      // same column written back in this cycle: read returns stale data
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // line RAM: each address holds the four previous lines of one column
  rwmf_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // column vector: slot k is the pixel k rows above the current one
  logic [LINE_W-1:0]                eff_line;
  logic [WIN_SIDE-1:0][PIX_W-1:0]   col_vec;

  assign eff_line = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    col_vec[0] = s1_pix;
    for (int k = 1; k < WIN_SIDE; k++) begin
      col_vec[k] = eff_line[(k-1)*PIX_W +: PIX_W];
    end
  end

  // write back the column shifted by one line
  assign wr_en   = adv && s1_valid && (s1_col < frame_width);
  assign wr_addr = s1_col[ADDR_W-1:0];
  assign wr_data = col_vec[STORED_LINES-1:0];

  // window mask: rows and columns inside both the window and the image
  logic [WIN_SIDE-1:0] row_ok;
  logic [WIN_SIDE-1:0] col_ok;
  logic [WIN_N-1:0]    mask_next;
  logic [CNT_W-1:0]    half_next;

  always_comb begin
    for (int k = 0; k < WIN_SIDE; k++) begin
      row_ok[k] = (3'(k) <= {radius, 1'b0}) && (s1_row >= ROW_W'(k)) &&
                  (s1_row < frame_height + ROW_W'(k));
      col_ok[k] = (3'(k) <= {radius, 1'b0}) && (s1_col >= COL_W'(k)) &&
                  (s1_col < frame_width + COL_W'(k));
    end
    for (int k = 0; k < WIN_SIDE; k++) begin
      for (int m = 0; m < WIN_SIDE; m++) begin
        mask_next[k*WIN_SIDE+m] = row_ok[k] && col_ok[m];
      end
    end
    half_next = CNT_W'($countones(mask_next)) >> 1;
  end

  // stage 2: window registers, column m is m steps old
  logic [PIX_W-1:0] window_regs [WIN_SIDE][WIN_SIDE];
  logic             s2_valid;
  logic [WIN_N-1:0] s2_mask;
  logic [CNT_W-1:0] s2_half;
  logic             s2_fe;

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      for (int k = 0; k < WIN_SIDE; k++) begin
        window_regs[0][k] <= col_vec[k];
      end
      for (int m = 1; m < WIN_SIDE; m++) begin
        window_regs[m] <= window_regs[m-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mask <= mask_next;
      s2_half <= half_next;
      s2_fe   <= s1_fe;
    end
  end

  // split the window into channels
  logic [WIN_N-1:0][CHAN_W-1:0] red_vals;
  logic [WIN_N-1:0][CHAN_W-1:0] green_vals;
  logic [WIN_N-1:0][CHAN_W-1:0] blue_vals;

  always_comb begin
    for (int k = 0; k < WIN_SIDE; k++) begin
      for (int m = 0; m < WIN_SIDE; m++) begin
        red_vals[k*WIN_SIDE+m]   = window_regs[m][k][PIX_W-1 -: CHAN_W];
        green_vals[k*WIN_SIDE+m] = window_regs[m][k][2*CHAN_W-1 -: CHAN_W];
        blue_vals[k*WIN_SIDE+m]  = window_regs[m][k][CHAN_W-1:0];
      end
    end
  end

  // per-channel rank selectors
  logic              red_valid;
  logic              green_valid;
  logic              blue_valid;
  logic [CHAN_W-1:0] red_med;
  logic [CHAN_W-1:0] green_med;
  logic [CHAN_W-1:0] blue_med;

  rwmf_rank_median u_red (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .valid       (s2_valid),
    .values      (red_vals),
    .mask        (s2_mask),
    .half        (s2_half),
    .result      (red_med),
    .result_valid(red_valid)
  );

  rwmf_rank_median u_green (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .valid       (s2_valid),
    .values      (green_vals),
    .mask        (s2_mask),
    .half        (s2_half),
    .result      (green_med),
    .result_valid(green_valid)
  );

  rwmf_rank_median u_blue (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .valid       (s2_valid),
    .values      (blue_vals),
    .mask        (s2_mask),
    .half        (s2_half),
    .result      (blue_med),
    .result_valid(blue_valid)
  );

  // frame end follows the selector stages
  logic fe_a;
  logic fe_b;
  logic fe_out;

  always_ff @(posedge clk) begin
    if (adv) begin
      fe_a   <= s2_fe;
      fe_b   <= fe_a;
      fe_out <= fe_b;
    end
  end

  assign med       = {red_med, green_med, blue_med, fe_out};
  assign med_valid = red_valid;

  // input held only while a result waits on the output
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> med_valid)
    else $error("input stalled without a held result");

  // a same-address read during write-back must be forwarded
  a_fwd: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en && (wr_addr == rd_addr)) |=> fwd_hit)
    else $error("line RAM forwarding missed");

  // channels stay in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (red_valid == green_valid) && (red_valid == blue_valid))
    else $error("channel selectors out of step");

  // an emitting step reaches the selector stage
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && s1_emit) |=> s2_valid)
    else $error("emitting step lost before selection");

endmodule

>>> test/tb_rgb_window_median_filter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_window_median_filter_top
// Streams whole frames through the median filter under several window and
// frame settings, with random idle cycles on the pixel side and random
// stalls on the result side. A scoreboard keeps its own line store,
// computes the clipped-window channel medians for every accepted pixel that
// releases a result and compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_rgb_window_median_filter_top;
  import rwmf_pkg::*;

  // scoreboard: frame geometry, line store and expected medians
  class median_book;
    int unsigned radius, width, height, col, row;
    logic [PIX_W-1:0] lines [WIN_SIDE][MAX_WIDTH];
    pix_out_t pending [$];
    int errors;

    function new();
      radius = 1; width = 512; height = 512; col = 0; row = 0; errors = 0;
    endfunction

    // clamped register write, grid position restarts
    function void set_reg(logic [1:0] idx, int unsigned val);
      case (idx)
        REG_RADIUS: radius = ((val & 3) > MAX_RADIUS) ? MAX_RADIUS : (val & 3);
        REG_FRAME_WIDTH: begin
          val = val & 10'h3ff;
          width = (val == 0) ? 1 : ((val > MAX_WIDTH) ? MAX_WIDTH : val);
        end
        REG_FRAME_HEIGHT: begin
          val = val & 13'h1fff;
          height = (val == 0) ? 1 : ((val > MAX_HEIGHT) ? MAX_HEIGHT : val);
        end
        default: return;
      endcase
      col = 0; row = 0;
    endfunction

    function logic [7:0] upper_median(logic [7:0] v [WIN_N], int n);
      logic [7:0] key;
      int j;
      for (int i = 1; i < n; i++) begin
        key = v[i];
        j = i;
        while (j > 0 && v[j-1] > key) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = key;
      end
      return v[n/2];
    endfunction

    // accepted pixel transfer: store it and predict the result it releases
    function void note_pixel(pix_in_t p);
      logic [7:0] rv [WIN_N];
      logic [7:0] gv [WIN_N];
      logic [7:0] bv [WIN_N];
      logic [PIX_W-1:0] q;
      int unsigned cx, cy, ylo, yhi, xlo, xhi, n;
      pix_out_t e;
      if (col < width && row < height) lines[row % WIN_SIDE][col] = p;
      if (col >= radius && row >= radius) begin
        cx = col - radius; cy = row - radius;
        ylo = (cy >= radius) ? cy - radius : 0;
        yhi = (cy + radius < height) ? cy + radius : height - 1;
        xlo = (cx >= radius) ? cx - radius : 0;
        xhi = (cx + radius < width) ? cx + radius : width - 1;
        n = 0;
        for (int unsigned y = ylo; y <= yhi; y++)
          for (int unsigned x = xlo; x <= xhi; x++) begin
            q = lines[y % WIN_SIDE][x];
            rv[n] = q[23:16]; gv[n] = q[15:8]; bv[n] = q[7:0];
            n++;
          end
        e.red_out = upper_median(rv, n);
        e.green_out = upper_median(gv, n);
        e.blue_out = upper_median(bv, n);
        e.frame_end = (cx == width - 1 && cy == height - 1);
        pending.push_back(e);
      end
      col++;
      if (col >= width + radius) begin
        col = 0;
        row++;
        if (row >= height + radius) row = 0;
      end
    endfunction

    // result transfer against the oldest expectation
    function void check_result(pix_out_t got);
      pix_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.red_out !== e.red_out || got.green_out !== e.green_out ||
          got.blue_out !== e.blue_out || got.frame_end !== e.frame_end) begin
        errors++;
        if (errors <= 10)
          $display("median mismatch: expected r%h g%h b%h end%b, got r%h g%h b%h end%b",
                   e.red_out, e.green_out, e.blue_out, e.frame_end,
                   got.red_out, got.green_out, got.blue_out, got.frame_end);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_en = 0;
  logic [1:0] cfg_index = REG_RADIUS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic pix_valid = 0;
  logic pix_stall;
  pix_in_t pix = '0;
  logic med_valid;
  logic med_stall = 0;
  pix_out_t med;
  logic no_idle = 0;
  int random_pixels = 0;

  median_book book = new();

  rgb_window_median_filter_top DUT (
    .clk(clk), .rst(rst), .cfg_en(cfg_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix_valid(pix_valid), .pix_stall(pix_stall),
    .pix(pix), .med_valid(med_valid), .med_stall(med_stall), .med(med)
  );

  always #4 clk = ~clk;

  // result side: random stalls, checked on every transfer
  always @(posedge clk) begin
    if (!rst && med_valid && !med_stall) book.check_result(med);
    med_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 20);
  end

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_en <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_en <= 0;
    book.set_reg(idx, val);
  endtask

  // wait for the pipeline to drain, then set a new geometry
  task automatic set_frame(int unsigned r, int unsigned w, int unsigned h);
    while (book.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    write_reg(REG_RADIUS, r);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic send_pixel(pix_in_t p);
    while (!no_idle && $urandom_range(0, 99) < 20) begin
      pix_valid <= 0;
      @(posedge clk);
    end
    pix <= p;
    pix_valid <= 1;
    do @(posedge clk); while (pix_stall);
    book.note_pixel(p);
  endtask

  // one full grid of random pixels, padding included
  task automatic send_frame();
    int unsigned total;
    total = (book.width + book.radius) * (book.height + book.radius);
    for (int unsigned i = 0; i < total; i++) send_pixel(pix_in_t'($urandom));
    pix_valid <= 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: 3x3 frame with extreme channel values
    set_frame(1, 3, 3);
    for (int i = 0; i < 16; i++)
      send_pixel({(i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'h00 : 8'hff,
                  (i < 8) ? 8'hff : 8'h00});
    pix_valid <= 0;

    // single pixel frames, out of range radius and zero size
    set_frame(0, 1, 1);
    send_frame();
    set_frame(3, 0, 0);
    send_frame();

    // stretch with no idling on either side
    no_idle <= 1;
    set_frame(2, 40, 6);
    send_frame();
    no_idle <= 0;

    // random small geometries
    while (random_pixels < 1100) begin
      set_frame($urandom_range(0, 2), $urandom_range(1, 20), $urandom_range(1, 12));
      random_pixels += (book.width + book.radius) * (book.height + book.radius);
      send_frame();
    end

    while (book.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
design/rwmf_pkg.sv
design/rwmf_ram.sv
design/rwmf_rank_median.sv
design/rgb_window_median_filter_top.sv
test/tb_rgb_window_median_filter_top.sv
